@@ rtl/pbf_pkg.sv @@
// Shared types and constants for the periodic box fold / minimum image block.
package pbf_pkg;

    // Register widths of the configuration file
    localparam int LEN_W       = 31;
    localparam int INV_W       = 49;
    localparam int CFG_DATA_W  = 49;
    localparam int CFG_INDEX_W = 3;

    // Reciprocal scale: inverse = 2^48 / length
    localparam int RECIP_SHIFT = 48;
    localparam logic [RECIP_SHIFT-1:0] REM_HALF = {1'b1, {(RECIP_SHIFT-1){1'b0}}};

    // Split of the reciprocal for the first multiplier
    localparam int INV_LO_W = 25;
    localparam int INV_HI_W = INV_W - INV_LO_W;

    // Wrap width of the remainder arithmetic
    localparam int WIDE_W = 64;

    // Lane pipeline depth
    localparam int NUM_STAGES = 10;

    // Reset values of the box registers
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(65536);
    localparam logic [INV_W-1:0] INV_RESET = INV_W'(64'h1_0000_0000);

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_LEN_X = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LEN_Y = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LEN_Z = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_X = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_Y = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_Z = 3'd5;

    // Operation codes
    localparam logic OP_FOLD  = 1'b0;
    localparam logic OP_IMAGE = 1'b1;

    // Per-stage load strobes from the pipeline control to the lanes
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } stage_ctl_t;

endpackage

@@ rtl/pbf_pipe_ctrl.sv @@
// Valid tracking and per-stage advance control for the lane pipeline.
module pbf_pipe_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output pbf_pkg::stage_ctl_t ctl
);

    localparam int N = pbf_pkg::NUM_STAGES;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    logic [N-1:0] ready;

    // A stage may take new data when it is empty or its content moves on
    always_comb begin
        ready[N-1] = !valid_reg[N-1] || out_ready;
        for (int i = N - 2; i >= 0; i--) begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
    end

    always_comb begin
        valid_next[0] = ready[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < N; i++) begin
            valid_next[i] = ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.load  = ready;
    assign in_ready  = ready[0];
    assign out_valid = valid_reg[N-1];

endmodule

@@ rtl/pbf_lane.sv @@
// One axis: fold into [0, L) or minimum image, as a ten-stage pipeline.
module pbf_lane #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic                            aclk,
    input  pbf_pkg::stage_ctl_t             ctl,
    input  logic                            op,
    input  logic [POSITION_WIDTH-1:0]       first_pos,
    input  logic [POSITION_WIDTH-1:0]       second_pos,
    input  logic [pbf_pkg::LEN_W-1:0]       box_len,
    input  logic [pbf_pkg::INV_W-1:0]       box_inv,
    output logic [POSITION_WIDTH-1:0]       result
);

    localparam int PW      = POSITION_WIDTH;
    localparam int MAG_W   = PW + 1;
    localparam int MLO_W   = (MAG_W + 1) / 2;
    localparam int MHI_W   = MAG_W - MLO_W;
    localparam int PLL_W   = MLO_W + pbf_pkg::INV_LO_W;
    localparam int PLH_W   = MLO_W + pbf_pkg::INV_HI_W;
    localparam int PHL_W   = MHI_W + pbf_pkg::INV_LO_W;
    localparam int PHH_W   = MHI_W + pbf_pkg::INV_HI_W;
    localparam int SLO_W   = MLO_W + pbf_pkg::INV_W;
    localparam int SHI_W   = MHI_W + pbf_pkg::INV_W;
    localparam int PROD_W  = MAG_W + pbf_pkg::INV_W;
    localparam int QW      = PROD_W - pbf_pkg::RECIP_SHIFT;
    localparam int QLO_W   = (QW + 1) / 2;
    localparam int QHI_W   = QW - QLO_W;
    localparam int QPL_W   = QLO_W + pbf_pkg::LEN_W;
    localparam int QPH_W   = QHI_W + pbf_pkg::LEN_W;
    localparam int WW      = pbf_pkg::WIDE_W;

    // stage 0: signed difference or plain position
    logic [MAG_W-1:0] v0_reg, v0_next;
    logic             op0_reg;
    // stage 1: magnitude
    logic [MAG_W-1:0] v1_reg, mag1_reg, mag1_next;
    logic             op1_reg;
    // stage 2: partial products of |v| * inverse
    logic [MAG_W-1:0] v2_reg;
    logic             op2_reg;
    logic [PLL_W-1:0] pll2_reg, pll2_next;
    logic [PLH_W-1:0] plh2_reg, plh2_next;
    logic [PHL_W-1:0] phl2_reg, phl2_next;
    logic [PHH_W-1:0] phh2_reg, phh2_next;
    // stage 3: per-half sums
    logic [MAG_W-1:0] v3_reg;
    logic             op3_reg;
    logic [SLO_W-1:0] slo3_reg, slo3_next;
    logic [SHI_W-1:0] shi3_reg, shi3_next;
    // stage 4: full product
    logic [MAG_W-1:0]  v4_reg;
    logic              op4_reg;
    logic [PROD_W-1:0] prod4_reg, prod4_next;
    // stage 5: quotient magnitude after floor / rounding
    logic [MAG_W-1:0] v5_reg;
    logic             op5_reg;
    logic [QW-1:0]    qm5_reg, qm5_next;
    // stage 6: partial products of quotient * length
    logic [MAG_W-1:0] v6_reg;
    logic             op6_reg, odd6_reg;
    logic [QPL_W-1:0] qpl6_reg, qpl6_next;
    logic [QPH_W-1:0] qph6_reg, qph6_next;
    // stage 7: quotient * length, wrapped
    logic [MAG_W-1:0] v7_reg;
    logic             op7_reg, odd7_reg;
    logic [WW-1:0]    qlen7_reg, qlen7_next;
    // stage 8: raw remainder
    logic             op8_reg, odd8_reg;
    logic [WW-1:0]    r8_reg, r8_next;
    // stage 9: corrected result
    logic [PW-1:0]    res9_reg, res9_next;

    logic                            inc5;
    logic [QW-1:0]                   q5;
    logic [pbf_pkg::RECIP_SHIFT-1:0] rem5;
    logic [WW-1:0]                   v7_wide;
    logic signed [WW-1:0]            s9, len9, half9, nhalf9;
    logic                            even9, sub9, add9;
    logic [PW-1:0]                   len_pw;

    always_comb begin
        if (op == pbf_pkg::OP_IMAGE) begin
            v0_next = {first_pos[PW-1], first_pos} - {second_pos[PW-1], second_pos};
        end else begin
            v0_next = {first_pos[PW-1], first_pos};
        end
    end

    assign mag1_next = v0_reg[MAG_W-1] ? (~v0_reg + MAG_W'(1)) : v0_reg;

    assign pll2_next = PLL_W'(mag1_reg[MLO_W-1:0])
                     * PLL_W'(box_inv[pbf_pkg::INV_LO_W-1:0]);
    assign plh2_next = PLH_W'(mag1_reg[MLO_W-1:0])
                     * PLH_W'(box_inv[pbf_pkg::INV_W-1:pbf_pkg::INV_LO_W]);
    assign phl2_next = PHL_W'(mag1_reg[MAG_W-1:MLO_W])
                     * PHL_W'(box_inv[pbf_pkg::INV_LO_W-1:0]);
    assign phh2_next = PHH_W'(mag1_reg[MAG_W-1:MLO_W])
                     * PHH_W'(box_inv[pbf_pkg::INV_W-1:pbf_pkg::INV_LO_W]);

    assign slo3_next = SLO_W'(pll2_reg) + (SLO_W'(plh2_reg) << pbf_pkg::INV_LO_W);
    assign shi3_next = SHI_W'(phl2_reg) + (SHI_W'(phh2_reg) << pbf_pkg::INV_LO_W);

    assign prod4_next = PROD_W'(slo3_reg) + (PROD_W'(shi3_reg) << MLO_W);

    // floor for fold (negative values round away), half-even for image
    assign q5   = prod4_reg[PROD_W-1:pbf_pkg::RECIP_SHIFT];
    assign rem5 = prod4_reg[pbf_pkg::RECIP_SHIFT-1:0];
    always_comb begin
        if (op4_reg == pbf_pkg::OP_IMAGE) begin
            inc5 = (rem5 > pbf_pkg::REM_HALF) || ((rem5 == pbf_pkg::REM_HALF) && q5[0]);
        end else begin
            inc5 = v4_reg[MAG_W-1] && (rem5 != '0);
        end
    end
    assign qm5_next = q5 + QW'(inc5);

    assign qpl6_next = QPL_W'(qm5_reg[QLO_W-1:0]) * QPL_W'(box_len);
    assign qph6_next = QPH_W'(qm5_reg[QW-1:QLO_W]) * QPH_W'(box_len);

    assign qlen7_next = WW'(qpl6_reg) + (WW'(qph6_reg) << QLO_W);

    assign v7_wide = {{(WW - MAG_W){v7_reg[MAG_W-1]}}, v7_reg};
    assign r8_next = v7_reg[MAG_W-1] ? (v7_wide + qlen7_reg) : (v7_wide - qlen7_reg);

    // one correction step into range
    assign s9     = signed'(r8_reg);
    assign len9   = signed'(WW'(box_len));
    assign half9  = signed'(WW'(box_len[pbf_pkg::LEN_W-1:1]));
    assign nhalf9 = -half9;
    assign even9  = !box_len[0];
    assign len_pw = PW'(box_len);

    always_comb begin
        if (op8_reg == pbf_pkg::OP_IMAGE) begin
            sub9 = (s9 > half9) || (even9 && (s9 == half9) && odd8_reg);
            add9 = !sub9 && ((s9 < nhalf9) || (even9 && (s9 == nhalf9) && odd8_reg));
        end else begin
            add9 = s9 < 0;
            sub9 = !add9 && (s9 >= len9);
        end
    end

    always_comb begin
        if (sub9) begin
            res9_next = r8_reg[PW-1:0] - len_pw;
        end else if (add9) begin
            res9_next = r8_reg[PW-1:0] + len_pw;
        end else begin
            res9_next = r8_reg[PW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            v0_reg  <= v0_next;
            op0_reg <= op;
        end
        if (ctl.load[1]) begin
            v1_reg   <= v0_reg;
            op1_reg  <= op0_reg;
            mag1_reg <= mag1_next;
        end
        if (ctl.load[2]) begin
            v2_reg   <= v1_reg;
            op2_reg  <= op1_reg;
            pll2_reg <= pll2_next;
            plh2_reg <= plh2_next;
            phl2_reg <= phl2_next;
            phh2_reg <= phh2_next;
        end
        if (ctl.load[3]) begin
            v3_reg   <= v2_reg;
            op3_reg  <= op2_reg;
            slo3_reg <= slo3_next;
            shi3_reg <= shi3_next;
        end
        if (ctl.load[4]) begin
            v4_reg    <= v3_reg;
            op4_reg   <= op3_reg;
            prod4_reg <= prod4_next;
        end
        if (ctl.load[5]) begin
            v5_reg  <= v4_reg;
            op5_reg <= op4_reg;
            qm5_reg <= qm5_next;
        end
        if (ctl.load[6]) begin
            v6_reg   <= v5_reg;
            op6_reg  <= op5_reg;
            odd6_reg <= qm5_reg[0];
            qpl6_reg <= qpl6_next;
            qph6_reg <= qph6_next;
        end
        if (ctl.load[7]) begin
            v7_reg    <= v6_reg;
            op7_reg   <= op6_reg;
            odd7_reg  <= odd6_reg;
            qlen7_reg <= qlen7_next;
        end
        if (ctl.load[8]) begin
            op8_reg  <= op7_reg;
            odd8_reg <= odd7_reg;
            r8_reg   <= r8_next;
        end
        if (ctl.load[9]) begin
            res9_reg <= res9_next;
        end
    end

    assign result = res9_reg;

endmodule

@@ rtl/periodic_box_fold_and_min_image_top.sv @@
// Top level: periodic box fold and minimum image, three axis lanes plus register file.
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  input     | s_tvalid / s_tready  | s_tuser: operation; s_tdata: positions
//  result    | m_tvalid / m_tready  | m_tdata: result_x, result_y, result_z
//  config    | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One transaction per cycle sustained while m_tready stays high; each result passes
// through every stage of the per-axis pipeline (two split multipliers, adds, fix-up).
// aresetn is synchronous, active low: clears the pipeline valid bits and loads
// the default box (length 1.0, reciprocal 2^32) into all three axes.
// A stalled m_tready only holds the stages that are full; empty stages upstream keep
// filling, so input is taken until the whole pipeline is occupied. cfg_ready is
// always high; write registers only with no transaction in flight; unchecked here.
module periodic_box_fold_and_min_image_top #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // input stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // fields from bit 0: first_x, first_y, first_z, second_x, second_y, second_z
    input  logic [((6*POSITION_WIDTH+7)/8)*8-1:0]  s_tdata,
    // fields from bit 0: operation
    input  logic                                   s_tuser,
    // result stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // fields from bit 0: result_x, result_y, result_z
    output logic [((3*POSITION_WIDTH+7)/8)*8-1:0]  m_tdata,
    // configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [pbf_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [pbf_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int PW       = POSITION_WIDTH;
    localparam int M_DATA_W = ((3*PW+7)/8)*8;

    pbf_pkg::stage_ctl_t ctl;

    logic [pbf_pkg::LEN_W-1:0] len_reg  [3];
    logic [pbf_pkg::LEN_W-1:0] len_next [3];
    logic [pbf_pkg::INV_W-1:0] inv_reg  [3];
    logic [pbf_pkg::INV_W-1:0] inv_next [3];
    logic [PW-1:0]             lane_res [3];

    // ------------------------------------------------------------------
    // Box register file
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_comb begin
        len_next = len_reg;
        inv_next = inv_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                pbf_pkg::REG_LEN_X: len_next[0] = cfg_data[pbf_pkg::LEN_W-1:0];
                pbf_pkg::REG_LEN_Y: len_next[1] = cfg_data[pbf_pkg::LEN_W-1:0];
                pbf_pkg::REG_LEN_Z: len_next[2] = cfg_data[pbf_pkg::LEN_W-1:0];
                pbf_pkg::REG_INV_X: inv_next[0] = cfg_data[pbf_pkg::INV_W-1:0];
                pbf_pkg::REG_INV_Y: inv_next[1] = cfg_data[pbf_pkg::INV_W-1:0];
                pbf_pkg::REG_INV_Z: inv_next[2] = cfg_data[pbf_pkg::INV_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                len_reg[i] <= pbf_pkg::LEN_RESET;
                inv_reg[i] <= pbf_pkg::INV_RESET;
            end
        end else begin
            len_reg <= len_next;
            inv_reg <= inv_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control shared by the three lanes
    // ------------------------------------------------------------------
    pbf_pipe_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .ctl       (ctl)
    );

    // ------------------------------------------------------------------
    // Axis lanes; lane i takes first at slot i and second at slot 3+i
    // ------------------------------------------------------------------
    for (genvar g = 0; g < 3; g++) begin : g_lane
        pbf_lane #(
            .POSITION_WIDTH (PW)
        ) u_lane (
            .aclk       (aclk),
            .ctl        (ctl),
            .op         (s_tuser),
            .first_pos  (s_tdata[g*PW +: PW]),
            .second_pos (s_tdata[(3+g)*PW +: PW]),
            .box_len    (len_reg[g]),
            .box_inv    (inv_reg[g]),
            .result     (lane_res[g])
        );
    end

    // Merge the lane outputs into one result transaction, zero padded
    assign m_tdata = M_DATA_W'({lane_res[2], lane_res[1], lane_res[0]});

endmodule
